>>> hw/rtl/three_level_priority_mailbox_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-level priority mailbox
// Shared property forms: same-cycle and next-cycle implication, both
// clocked on the rising edge and held off while reset is high.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_MAILBOX_UNIT_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_MAILBOX_UNIT_DEFINES_SVH

// Check that the consequent holds in the cycle of the antecedent.
`define TLPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mailbox check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define TLPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mailbox check failed");

`endif

>>> hw/rtl/tlpm_pkg.sv
// ----------------------------------------------------------------------------
// tlpm_pkg
// Shared types, codes and sizes of the three-level priority mailbox.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpm_pkg;

   localparam int HIGH_DEPTH   = 8;
   localparam int NORMAL_DEPTH = 64;
   localparam int LOW_DEPTH    = 8;
   localparam int PAYLOAD_BITS = 32;
   // Bits of the payload carried through a queue
   localparam int PAYLOAD_KEEP = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;

   localparam int HIGH_AW   = $clog2(HIGH_DEPTH);
   localparam int HIGH_FW   = $clog2(HIGH_DEPTH + 1);
   localparam int NORMAL_AW = $clog2(NORMAL_DEPTH);
   localparam int NORMAL_FW = $clog2(NORMAL_DEPTH + 1);
   localparam int LOW_AW    = $clog2(LOW_DEPTH);
   localparam int LOW_FW    = $clog2(LOW_DEPTH + 1);

   // Operation codes
   localparam logic [1:0] OP_ROUTED = 2'd0;
   localparam logic [1:0] OP_DIRECT = 2'd1;
   localparam logic [1:0] OP_GET    = 2'd2;

   // Priority codes
   localparam logic [1:0] PRIO_NORMAL = 2'd1;
   localparam logic [1:0] PRIO_LOW    = 2'd2;

   // Queue codes
   localparam logic [1:0] Q_HIGH   = 2'd0;
   localparam logic [1:0] Q_NORMAL = 2'd1;
   localparam logic [1:0] Q_LOW    = 2'd2;

   // Result status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Register indexes
   localparam logic REG_NO_PANIC      = 1'b0;
   localparam logic REG_DIRECT_TARGET = 1'b1;

   typedef struct packed {
      logic [PAYLOAD_KEEP-1:0] payload;
      logic [31:0]             time_ms;
      logic [31:0]             seq;
      logic [1:0]              prio;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic is_get;
   } stat_type;

endpackage

>>> hw/rtl/three_level_priority_mailbox_unit.sv
// ----------------------------------------------------------------------------
// three_level_priority_mailbox_unit
// A post steps through capture, execute and respond; a get adds a load step
// before respond for the registered read port of the queue RAMs. One item
// at a time: a new request is taken only after the result side has taken
// the last result.
// Reset (synchronous): queues empty, counters and control registers zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "three_level_priority_mailbox_unit_defines.svh"

module three_level_priority_mailbox_unit (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [1:0]  req_priority_req,
   input  logic [31:0] req_payload,
   input  logic [31:0] req_time_ms,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_fatal,
   output logic [31:0] rsp_out_payload,
   output logic [1:0]  rsp_out_priority,
   output logic [31:0] rsp_out_seq,
   output logic [31:0] rsp_out_time,
   output logic [1:0]  rsp_which_queue,
   output logic [15:0] rsp_error_count,
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Control registers: no_panic at byte 0, direct_target at byte 4
   logic no_panic_ff, no_panic_in;
   logic direct_target_ff, direct_target_in;
   logic csr_write;

   tlpm_pkg::cmd_type  cmd;
   tlpm_pkg::stat_type stat;

   // The port never stalls
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Decode on the register index bit; the low bits of the address select
   // nothing and are ignored.
   always_comb begin
      no_panic_in      = no_panic_ff;
      direct_target_in = direct_target_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            tlpm_pkg::REG_NO_PANIC:      no_panic_in      = csr_pwdata[0];
            tlpm_pkg::REG_DIRECT_TARGET: direct_target_in = csr_pwdata[0];
            default:                     no_panic_in      = no_panic_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         no_panic_ff      <= 1'b0;
         direct_target_ff <= 1'b0;
      end else begin
         no_panic_ff      <= no_panic_in;
         direct_target_ff <= direct_target_in;
      end
   end

   // Read back the addressed register, zero-extended
   always_comb begin
      unique case (csr_paddr[2])
         tlpm_pkg::REG_NO_PANIC:      csr_prdata = {31'd0, no_panic_ff};
         tlpm_pkg::REG_DIRECT_TARGET: csr_prdata = {31'd0, direct_target_ff};
         default:                     csr_prdata = '0;
      endcase
   end

   // Sequencer: idle -> execute -> (load on a get) -> respond
   tlpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Queues, counters and the result beat
   tlpm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .no_panic         (no_panic_ff),
      .direct_target    (direct_target_ff),
      .req_operation    (req_operation),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .req_time_ms      (req_time_ms),
      .rsp_status       (rsp_status),
      .rsp_fatal        (rsp_fatal),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_seq      (rsp_out_seq),
      .rsp_out_time     (rsp_out_time),
      .rsp_which_queue  (rsp_which_queue),
      .rsp_error_count  (rsp_error_count)
   );

   // One item in flight: never ready for a request while a result is shown
   `TLPM_ASSERT_NOW(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   // An accepted request always moves the sequencer out of idle
   `TLPM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // Fatal only comes with a full queue and panics enabled
   `TLPM_ASSERT_NOW(a_fatal_cause, clock, reset, rsp_valid && rsp_fatal,
                    rsp_status == tlpm_pkg::STATUS_FULL && !no_panic_ff)
   // An empty get reports the high queue and a cleared message
   `TLPM_ASSERT_NOW(a_empty_get, clock, reset,
                    rsp_valid && rsp_status == tlpm_pkg::STATUS_EMPTY,
                    rsp_which_queue == tlpm_pkg::Q_HIGH && rsp_out_seq == 32'd0)

endmodule

>>> hw/rtl/tlpm_ram.sv
// ----------------------------------------------------------------------------
// tlpm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpm_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tlpm_ctrl.sv
// ----------------------------------------------------------------------------
// tlpm_ctrl
// Sequencer: accept one beat, execute it, fetch queue data on a get, present result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  tlpm_pkg::stat_type stat,
   output tlpm_pkg::cmd_type  cmd
);

   tlpm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlpm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlpm_pkg::ST_IDLE: begin
            if (req_valid) state_in = tlpm_pkg::ST_EXEC;
         end
         tlpm_pkg::ST_EXEC: begin
            state_in = stat.is_get ? tlpm_pkg::ST_LOAD : tlpm_pkg::ST_RESP;
         end
         tlpm_pkg::ST_LOAD: begin
            state_in = tlpm_pkg::ST_RESP;
         end
         tlpm_pkg::ST_RESP: begin
            if (rsp_ready) state_in = tlpm_pkg::ST_IDLE;
         end
         default: begin
            state_in = tlpm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         tlpm_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         tlpm_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         tlpm_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
         end
         tlpm_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> hw/rtl/tlpm_datapath.sv
// ----------------------------------------------------------------------------
// tlpm_datapath
// Three queues with their pointers, sequence and error counters, result
// registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpm_datapath (
   input  logic               clock,
   input  logic               reset,
   input  tlpm_pkg::cmd_type  cmd,
   output tlpm_pkg::stat_type stat,
   input  logic               no_panic,
   input  logic               direct_target,
   input  logic [1:0]         req_operation,
   input  logic [1:0]         req_priority_req,
   input  logic [31:0]        req_payload,
   input  logic [31:0]        req_time_ms,
   output logic [1:0]         rsp_status,
   output logic               rsp_fatal,
   output logic [31:0]        rsp_out_payload,
   output logic [1:0]         rsp_out_priority,
   output logic [31:0]        rsp_out_seq,
   output logic [31:0]        rsp_out_time,
   output logic [1:0]         rsp_which_queue,
   output logic [15:0]        rsp_error_count
);

   // Captured beat
   logic [1:0]                      op_ff;
   logic [1:0]                      prio_ff;
   logic [tlpm_pkg::PAYLOAD_KEEP-1:0] pay_ff;
   logic [31:0]                     time_ff;

   // Queue pointers
   logic [tlpm_pkg::HIGH_AW-1:0]   hi_head_ff, hi_head_in, hi_tail_ff, hi_tail_in;
   logic [tlpm_pkg::HIGH_FW-1:0]   hi_fill_ff, hi_fill_in;
   logic [tlpm_pkg::NORMAL_AW-1:0] no_head_ff, no_head_in, no_tail_ff, no_tail_in;
   logic [tlpm_pkg::NORMAL_FW-1:0] no_fill_ff, no_fill_in;
   logic [tlpm_pkg::LOW_AW-1:0]    lo_head_ff, lo_head_in, lo_tail_ff, lo_tail_in;
   logic [tlpm_pkg::LOW_FW-1:0]    lo_fill_ff, lo_fill_in;

   logic [31:0] seq_ff, seq_in;
   logic [15:0] fail_ff, fail_in;

   // Pending get selection, kept for the load step
   logic [1:0] sel_q_ff, sel_q_in;
   logic       got_ff, got_in;

   // Result registers
   logic [1:0]  status_ff, status_in;
   logic        fatal_ff, fatal_in;
   logic [31:0] opay_ff, opay_in;
   logic [1:0]  oprio_ff, oprio_in;
   logic [31:0] oseq_ff, oseq_in;
   logic [31:0] otime_ff, otime_in;
   logic [1:0]  which_ff, which_in;
   logic [15:0] errc_ff, errc_in;

   logic hi_empty, no_empty, lo_empty, hi_full, no_full, lo_full;
   logic is_post, is_get, all_empty, tgt_full, push_ok;
   logic [1:0] target;
   logic hi_push, no_push, lo_push, hi_pop, no_pop, lo_pop;
   logic [31:0] seq_next;
   tlpm_pkg::entry_type wr_entry, hi_rd, no_rd, lo_rd, sel_rd;

   assign hi_empty = (hi_fill_ff == '0);
   assign no_empty = (no_fill_ff == '0);
   assign lo_empty = (lo_fill_ff == '0);
   assign hi_full  = (hi_fill_ff == tlpm_pkg::HIGH_FW'(tlpm_pkg::HIGH_DEPTH));
   assign no_full  = (no_fill_ff == tlpm_pkg::NORMAL_FW'(tlpm_pkg::NORMAL_DEPTH));
   assign lo_full  = (lo_fill_ff == tlpm_pkg::LOW_FW'(tlpm_pkg::LOW_DEPTH));

   assign is_post   = (op_ff == tlpm_pkg::OP_ROUTED) || (op_ff == tlpm_pkg::OP_DIRECT);
   assign is_get    = (op_ff == tlpm_pkg::OP_GET);
   assign all_empty = hi_empty && no_empty && lo_empty;
   assign stat.is_get = is_get;

   // Pick the target queue of a post
   always_comb begin
      if (op_ff == tlpm_pkg::OP_DIRECT) begin
         target = direct_target ? tlpm_pkg::Q_LOW : tlpm_pkg::Q_NORMAL;
      end else if (all_empty) begin
         target = tlpm_pkg::Q_HIGH;
      end else if (prio_ff == tlpm_pkg::PRIO_NORMAL) begin
         target = tlpm_pkg::Q_NORMAL;
      end else if (prio_ff == tlpm_pkg::PRIO_LOW) begin
         target = tlpm_pkg::Q_LOW;
      end else begin
         target = tlpm_pkg::Q_HIGH;
      end
   end

   always_comb begin
      case (target)
         tlpm_pkg::Q_NORMAL: tgt_full = no_full;
         tlpm_pkg::Q_LOW:    tgt_full = lo_full;
         default:            tgt_full = hi_full;
      endcase
   end

   assign push_ok  = cmd.execute && is_post && !tgt_full;
   assign hi_push  = push_ok && (target == tlpm_pkg::Q_HIGH);
   assign no_push  = push_ok && (target == tlpm_pkg::Q_NORMAL);
   assign lo_push  = push_ok && (target == tlpm_pkg::Q_LOW);
   assign hi_pop   = cmd.execute && is_get && !hi_empty;
   assign no_pop   = cmd.execute && is_get && hi_empty && !no_empty;
   assign lo_pop   = cmd.execute && is_get && hi_empty && no_empty && !lo_empty;
   assign seq_next = seq_ff + 32'd1;

   assign wr_entry.payload = pay_ff;
   assign wr_entry.time_ms = time_ff;
   assign wr_entry.seq     = seq_next;
   assign wr_entry.prio    = prio_ff;

   // Pointer and counter updates
   always_comb begin
      hi_head_in = hi_head_ff;
      hi_tail_in = hi_tail_ff;
      hi_fill_in = hi_fill_ff;
      no_head_in = no_head_ff;
      no_tail_in = no_tail_ff;
      no_fill_in = no_fill_ff;
      lo_head_in = lo_head_ff;
      lo_tail_in = lo_tail_ff;
      lo_fill_in = lo_fill_ff;
      seq_in     = seq_ff;
      fail_in    = fail_ff;
      if (hi_push) begin
         hi_tail_in = (hi_tail_ff == tlpm_pkg::HIGH_AW'(tlpm_pkg::HIGH_DEPTH - 1)) ?
                      '0 : hi_tail_ff + 1'b1;
         hi_fill_in = hi_fill_ff + 1'b1;
      end
      if (no_push) begin
         no_tail_in = (no_tail_ff == tlpm_pkg::NORMAL_AW'(tlpm_pkg::NORMAL_DEPTH - 1)) ?
                      '0 : no_tail_ff + 1'b1;
         no_fill_in = no_fill_ff + 1'b1;
      end
      if (lo_push) begin
         lo_tail_in = (lo_tail_ff == tlpm_pkg::LOW_AW'(tlpm_pkg::LOW_DEPTH - 1)) ?
                      '0 : lo_tail_ff + 1'b1;
         lo_fill_in = lo_fill_ff + 1'b1;
      end
      if (hi_pop) begin
         hi_head_in = (hi_head_ff == tlpm_pkg::HIGH_AW'(tlpm_pkg::HIGH_DEPTH - 1)) ?
                      '0 : hi_head_ff + 1'b1;
         hi_fill_in = hi_fill_ff - 1'b1;
      end
      if (no_pop) begin
         no_head_in = (no_head_ff == tlpm_pkg::NORMAL_AW'(tlpm_pkg::NORMAL_DEPTH - 1)) ?
                      '0 : no_head_ff + 1'b1;
         no_fill_in = no_fill_ff - 1'b1;
      end
      if (lo_pop) begin
         lo_head_in = (lo_head_ff == tlpm_pkg::LOW_AW'(tlpm_pkg::LOW_DEPTH - 1)) ?
                      '0 : lo_head_ff + 1'b1;
         lo_fill_in = lo_fill_ff - 1'b1;
      end
      if (cmd.execute && is_post) begin
         seq_in = seq_next;
         if (tgt_full && (op_ff == tlpm_pkg::OP_ROUTED) && (fail_ff != 16'hFFFF)) begin
            fail_in = fail_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hi_head_ff <= '0;
         hi_tail_ff <= '0;
         hi_fill_ff <= '0;
         no_head_ff <= '0;
         no_tail_ff <= '0;
         no_fill_ff <= '0;
         lo_head_ff <= '0;
         lo_tail_ff <= '0;
         lo_fill_ff <= '0;
         seq_ff     <= '0;
         fail_ff    <= '0;
      end else begin
         hi_head_ff <= hi_head_in;
         hi_tail_ff <= hi_tail_in;
         hi_fill_ff <= hi_fill_in;
         no_head_ff <= no_head_in;
         no_tail_ff <= no_tail_in;
         no_fill_ff <= no_fill_in;
         lo_head_ff <= lo_head_in;
         lo_tail_ff <= lo_tail_in;
         lo_fill_ff <= lo_fill_in;
         seq_ff     <= seq_in;
         fail_ff    <= fail_in;
      end
   end

   // Hold the beat fields
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         prio_ff <= req_priority_req;
         pay_ff  <= req_payload[tlpm_pkg::PAYLOAD_KEEP-1:0];
         time_ff <= req_time_ms;
      end
   end

   // Queue stores
   tlpm_ram #(.DEPTH(tlpm_pkg::HIGH_DEPTH), .WIDTH(tlpm_pkg::ENTRY_BITS)) u_high_ram (
      .clock   (clock),
      .wr_en   (hi_push),
      .wr_addr (hi_tail_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.execute),
      .rd_addr (hi_head_ff),
      .rd_data (hi_rd)
   );

   tlpm_ram #(.DEPTH(tlpm_pkg::NORMAL_DEPTH), .WIDTH(tlpm_pkg::ENTRY_BITS)) u_normal_ram (
      .clock   (clock),
      .wr_en   (no_push),
      .wr_addr (no_tail_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.execute),
      .rd_addr (no_head_ff),
      .rd_data (no_rd)
   );

   tlpm_ram #(.DEPTH(tlpm_pkg::LOW_DEPTH), .WIDTH(tlpm_pkg::ENTRY_BITS)) u_low_ram (
      .clock   (clock),
      .wr_en   (lo_push),
      .wr_addr (lo_tail_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.execute),
      .rd_addr (lo_head_ff),
      .rd_data (lo_rd)
   );

   always_comb begin
      case (sel_q_ff)
         tlpm_pkg::Q_NORMAL: sel_rd = no_rd;
         tlpm_pkg::Q_LOW:    sel_rd = lo_rd;
         default:            sel_rd = hi_rd;
      endcase
   end

   // Result assembly: a get finishes in the load step, all else in execute
   always_comb begin
      sel_q_in  = sel_q_ff;
      got_in    = got_ff;
      status_in = status_ff;
      fatal_in  = fatal_ff;
      opay_in   = opay_ff;
      oprio_in  = oprio_ff;
      oseq_in   = oseq_ff;
      otime_in  = otime_ff;
      which_in  = which_ff;
      errc_in   = errc_ff;
      if (cmd.execute) begin
         got_in   = hi_pop || no_pop || lo_pop;
         sel_q_in = hi_pop ? tlpm_pkg::Q_HIGH :
                    no_pop ? tlpm_pkg::Q_NORMAL :
                    lo_pop ? tlpm_pkg::Q_LOW : tlpm_pkg::Q_HIGH;
         if (!is_get) begin
            status_in = (is_post && tgt_full) ? tlpm_pkg::STATUS_FULL : tlpm_pkg::STATUS_DONE;
            fatal_in  = is_post && tgt_full && (op_ff == tlpm_pkg::OP_ROUTED) && !no_panic;
            opay_in   = '0;
            oprio_in  = '0;
            otime_in  = '0;
            oseq_in   = is_post ? seq_next : '0;
            which_in  = is_post ? target : tlpm_pkg::Q_HIGH;
            errc_in   = fail_in;
         end
      end
      if (cmd.load) begin
         status_in = got_ff ? tlpm_pkg::STATUS_DONE : tlpm_pkg::STATUS_EMPTY;
         fatal_in  = 1'b0;
         opay_in   = got_ff ? 32'(sel_rd.payload) : '0;
         oprio_in  = got_ff ? sel_rd.prio : '0;
         oseq_in   = got_ff ? sel_rd.seq : '0;
         otime_in  = got_ff ? sel_rd.time_ms : '0;
         which_in  = sel_q_ff;
         errc_in   = fail_ff;
      end
   end

   always_ff @(posedge clock) begin
      sel_q_ff  <= sel_q_in;
      got_ff    <= got_in;
      status_ff <= status_in;
      fatal_ff  <= fatal_in;
      opay_ff   <= opay_in;
      oprio_ff  <= oprio_in;
      oseq_ff   <= oseq_in;
      otime_ff  <= otime_in;
      which_ff  <= which_in;
      errc_ff   <= errc_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_fatal        = fatal_ff;
   assign rsp_out_payload  = opay_ff;
   assign rsp_out_priority = oprio_ff;
   assign rsp_out_seq      = oseq_ff;
   assign rsp_out_time     = otime_ff;
   assign rsp_which_queue  = which_ff;
   assign rsp_error_count  = errc_ff;

endmodule

>>> sim/three_level_priority_mailbox_unit_test.sv
// ----------------------------------------------------------------------------
// three_level_priority_mailbox_unit_test
// Self-checking bench for the three-level priority mailbox: a directed table
// covers empty gets, unknown operations, routing and a full high queue. It is
// followed by randomized post/get traffic under four register settings and
// four idle patterns, and by a short overflow run of the normal and high
// queues. Replies are checked against a bench predictor or a typed table row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_level_priority_mailbox_unit_test;

   // Codes that the package does not name
   localparam logic [1:0] OP_UNKNOWN = 2'd3;
   localparam logic [1:0] PRIO_HIGH  = 2'd0;
   localparam logic [1:0] PRIO_OTHER = 2'd3;

   localparam int unsigned LIMIT_CYCLES = 2_000_000;
   localparam int unsigned DRAIN_SLACK  = 6;
   localparam int unsigned RANDOM_BEATS = 110;

   // Settings per random phase: both registers reach both values, and the
   // four idle patterns are none, sender only, receiver only, both.
   localparam logic        PHASE_NO_PANIC [4] = '{1'b1, 1'b0, 1'b1, 1'b0};
   localparam logic        PHASE_DIRECT   [4] = '{1'b1, 1'b1, 1'b0, 1'b0};
   localparam int unsigned PHASE_SEND     [4] = '{0, 55, 0, 26};
   localparam int unsigned PHASE_RECV     [4] = '{0, 0, 55, 26};

   // One reply beat, field for field as on the rsp_ ports
   typedef struct packed {
      logic [1:0]  status;
      logic        fatal;
      logic [31:0] payload;
      logic [1:0]  prio;
      logic [31:0] seq;
      logic [31:0] stamp;
      logic [1:0]  queue;
      logic [15:0] errors;
   } reply_type;

   // One stored message
   typedef struct packed {
      logic [31:0] payload;
      logic [31:0] stamp;
      logic [31:0] seq;
      logic [1:0]  prio;
   } letter_type;

   // One row of the directed table; typed rows carry their own reply
   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  prio;
      logic [31:0] payload;
      logic [31:0] stamp;
      logic        typed;
      reply_type   want;
   } drill_row_type;

   localparam reply_type NO_REPLY = '0;

   // Directed table. After reset: empty get, unknown operation, one routed
   // post into empty queues (lands in high whatever its priority), one post
   // per route, drain back to empty, then fill the high queue and overflow it
   // with no_panic clear so that fatal is raised and the failure count moves.
   localparam int unsigned DRILL_ROWS = 24;
   localparam drill_row_type DRILL [DRILL_ROWS] = '{
      '{tlpm_pkg::OP_GET, PRIO_HIGH, 32'h0, 32'h0, 1'b1,
        '{tlpm_pkg::STATUS_EMPTY, 1'b0, 32'h0, 2'd0, 32'd0, 32'h0,
          tlpm_pkg::Q_HIGH, 16'd0}},
      '{OP_UNKNOWN, PRIO_OTHER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{tlpm_pkg::STATUS_DONE, 1'b0, 32'h0, 2'd0, 32'd0, 32'h0,
          tlpm_pkg::Q_HIGH, 16'd0}},
      '{tlpm_pkg::OP_ROUTED, tlpm_pkg::PRIO_NORMAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{tlpm_pkg::STATUS_DONE, 1'b0, 32'h0, 2'd0, 32'd1, 32'h0,
          tlpm_pkg::Q_HIGH, 16'd0}},
      '{tlpm_pkg::OP_ROUTED, tlpm_pkg::PRIO_NORMAL, 32'h0, 32'h0, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, tlpm_pkg::PRIO_LOW, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0,
        NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_OTHER, 32'h1234_5678, 32'h8765_4321, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_DIRECT, PRIO_HIGH, 32'hDEAD_BEEF, 32'h0000_0001, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_GET, PRIO_HIGH, 32'h0, 32'h0, 1'b1,
        '{tlpm_pkg::STATUS_DONE, 1'b0, 32'hFFFF_FFFF, tlpm_pkg::PRIO_NORMAL, 32'd1,
          32'hFFFF_FFFF, tlpm_pkg::Q_HIGH, 16'd0}},
      '{tlpm_pkg::OP_GET, tlpm_pkg::PRIO_LOW, 32'h0, 32'h0, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_GET, tlpm_pkg::PRIO_NORMAL, 32'h0, 32'h0, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_GET, PRIO_OTHER, 32'h0, 32'h0, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_GET, PRIO_HIGH, 32'h0, 32'h0, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_GET, PRIO_HIGH, 32'h0, 32'h0, 1'b1,
        '{tlpm_pkg::STATUS_EMPTY, 1'b0, 32'h0, 2'd0, 32'd0, 32'h0,
          tlpm_pkg::Q_HIGH, 16'd0}},
      '{tlpm_pkg::OP_ROUTED, PRIO_HIGH, 32'h0000_0001, 32'h8000_0000, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_HIGH, 32'h0000_0002, 32'h4000_0000, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_OTHER, 32'h0000_0004, 32'h2000_0000, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_HIGH, 32'h0000_0008, 32'h1000_0000, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_OTHER, 32'h8000_0000, 32'h0000_0010, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_HIGH, 32'h4000_0000, 32'h0000_0020, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_HIGH, 32'h2000_0000, 32'h0000_0040, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_OTHER, 32'h1000_0000, 32'h0000_0080, 1'b0, NO_REPLY},
      '{tlpm_pkg::OP_ROUTED, PRIO_HIGH, 32'hCAFE_F00D, 32'h0BAD_F00D, 1'b1,
        '{tlpm_pkg::STATUS_FULL, 1'b1, 32'h0, 2'd0, 32'd14, 32'h0,
          tlpm_pkg::Q_HIGH, 16'd1}},
      '{tlpm_pkg::OP_ROUTED, tlpm_pkg::PRIO_NORMAL, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0,
        NO_REPLY},
      '{tlpm_pkg::OP_GET, PRIO_HIGH, 32'h0, 32'h0, 1'b0, NO_REPLY}
   };

   // ------------------------------------------------------------------------
   // Clock, reset and block inputs; everything starts at a known value
   // ------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [1:0]  req_operation = '0;
   logic [1:0]  req_priority_req = '0;
   logic [31:0] req_payload = '0;
   logic [31:0] req_time_ms = '0;
   logic        rsp_ready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;

   // Bench-side companions of the request beat: they move with the payload
   logic        req_typed = 1'b0;
   reply_type   req_expect = '0;

   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_fatal;
   logic [31:0] rsp_out_payload;
   logic [1:0]  rsp_out_priority;
   logic [31:0] rsp_out_seq;
   logic [31:0] rsp_out_time;
   logic [1:0]  rsp_which_queue;
   logic [15:0] rsp_error_count;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   three_level_priority_mailbox_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_priority_req (req_priority_req),
      .req_payload      (req_payload),
      .req_time_ms      (req_time_ms),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_fatal        (rsp_fatal),
      .rsp_out_payload  (rsp_out_payload),
      .rsp_out_priority (rsp_out_priority),
      .rsp_out_seq      (rsp_out_seq),
      .rsp_out_time     (rsp_out_time),
      .rsp_which_queue  (rsp_which_queue),
      .rsp_error_count  (rsp_error_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Mailbox predictor: its own copy of the queues, counters and registers
   // ------------------------------------------------------------------------
   letter_type  box_mem   [3][tlpm_pkg::NORMAL_DEPTH];
   int unsigned box_head  [3];
   int unsigned box_fill  [3];
   int unsigned box_depth [3] = '{tlpm_pkg::HIGH_DEPTH, tlpm_pkg::NORMAL_DEPTH,
                                  tlpm_pkg::LOW_DEPTH};
   logic [31:0] seq_count = '0;
   logic [15:0] fail_count = '0;
   logic        no_panic_q = 1'b0;
   logic        direct_target_q = 1'b0;

   // Advance the predictor by one request beat and return the reply it owes.
   function automatic reply_type predict_mailbox(logic [1:0] op, logic [1:0] prio,
                                                 logic [31:0] payload,
                                                 logic [31:0] stamp);
      reply_type   r;
      logic [1:0]  tgt;
      int unsigned q;
      int unsigned slot;
      logic        got;
      r = '0;
      got = 1'b0;
      if (op == tlpm_pkg::OP_ROUTED || op == tlpm_pkg::OP_DIRECT) begin
         if (op == tlpm_pkg::OP_DIRECT)
            tgt = direct_target_q ? tlpm_pkg::Q_LOW : tlpm_pkg::Q_NORMAL;
         else if (box_fill[tlpm_pkg::Q_HIGH] == 0 && box_fill[tlpm_pkg::Q_NORMAL] == 0 &&
                  box_fill[tlpm_pkg::Q_LOW] == 0)
            tgt = tlpm_pkg::Q_HIGH;
         else if (prio == tlpm_pkg::PRIO_NORMAL)
            tgt = tlpm_pkg::Q_NORMAL;
         else if (prio == tlpm_pkg::PRIO_LOW)
            tgt = tlpm_pkg::Q_LOW;
         else
            tgt = tlpm_pkg::Q_HIGH;
         // The number is used up whether or not the push succeeds
         seq_count = seq_count + 32'd1;
         r.seq = seq_count;
         r.queue = tgt;
         q = int'(tgt);
         if (box_fill[q] < box_depth[q]) begin
            slot = (box_head[q] + box_fill[q]) % box_depth[q];
            box_mem[q][slot] = '{payload, stamp, seq_count, prio};
            box_fill[q]++;
         end else begin
            r.status = tlpm_pkg::STATUS_FULL;
            // Only routed posts count failures and raise fatal
            if (op == tlpm_pkg::OP_ROUTED) begin
               if (fail_count != 16'hFFFF)
                  fail_count = fail_count + 16'd1;
               r.fatal = ~no_panic_q;
            end
         end
      end else if (op == tlpm_pkg::OP_GET) begin
         // Strict priority: high, then normal, then low
         for (q = 0; q < 3; q++) begin
            if (!got && box_fill[q] != 0) begin
               slot = box_head[q];
               r.payload = box_mem[q][slot].payload;
               r.prio = box_mem[q][slot].prio;
               r.seq = box_mem[q][slot].seq;
               r.stamp = box_mem[q][slot].stamp;
               r.queue = 2'(q);
               box_head[q] = (slot + 1) % box_depth[q];
               box_fill[q]--;
               got = 1'b1;
            end
         end
         if (!got)
            r.status = tlpm_pkg::STATUS_EMPTY;
      end
      r.errors = fail_count;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------------
   int unsigned mismatch_count = 0;

   // Count every mismatch and print one line for it.
   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("mismatch: %s", what);
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // ------------------------------------------------------------------------
   // Scoreboard. All bench drives and all block registers change in the NBA
   // region, so values read here are the ones present before the edge.
   // ------------------------------------------------------------------------
   reply_type   pending_replies [$];
   int unsigned beats_sent = 0;
   int unsigned replies_seen = 0;

   always @(posedge clock) begin : scoreboard
      reply_type want;
      if (!reset) begin
         // Predict on every accepted request beat, in acceptance order
         if (req_valid && req_ready) begin
            want = predict_mailbox(req_operation, req_priority_req, req_payload,
                                   req_time_ms);
            if (req_typed)
               want = req_expect;
            pending_replies.push_back(want);
         end
         // Check every accepted reply beat against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (pending_replies.size() == 0) begin
               report_mismatch("reply beat with nothing pending");
            end else begin
               want = pending_replies.pop_front();
               compare_field("status", 32'(rsp_status), 32'(want.status));
               compare_field("fatal", 32'(rsp_fatal), 32'(want.fatal));
               compare_field("out_payload", rsp_out_payload, want.payload);
               compare_field("out_priority", 32'(rsp_out_priority), 32'(want.prio));
               compare_field("out_seq", rsp_out_seq, want.seq);
               compare_field("out_time", rsp_out_time, want.stamp);
               compare_field("which_queue", 32'(rsp_which_queue), 32'(want.queue));
               compare_field("error_count", 32'(rsp_error_count), 32'(want.errors));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver back-pressure and the run-time watchdog
   // ------------------------------------------------------------------------
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count = 0;

   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers; each is entered and left just after a rising edge
   // ------------------------------------------------------------------------

   // Drive one request beat and hold it until accepted. Idle cycles in front
   // of the beat follow send_idle_pct; valid stays high into the next beat.
   task automatic send_beat(logic [1:0] op, logic [1:0] prio, logic [31:0] payload,
                            logic [31:0] stamp, logic typed, reply_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_priority_req <= prio;
      req_payload <= payload;
      req_time_ms <= stamp;
      req_typed <= typed;
      req_expect <= want;
      do
         @(posedge clock);
      while (!req_ready);
      beats_sent++;
   endtask

   // Drop valid and hold until every accepted beat has been answered, then
   // let the block settle.
   task automatic drain_replies();
      req_valid <= 1'b0;
      while (replies_seen < beats_sent)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // Write one register over the APB port, then read it back.
   task automatic csr_write(logic idx, logic value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (idx == tlpm_pkg::REG_NO_PANIC)
         no_panic_q = value;
      else
         direct_target_q = value;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      if (csr_prdata !== 32'(value))
         report_mismatch($sformatf("register %0d read %0h want %0h", idx, csr_prdata,
                                   value));
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Zero, all ones, or a random word.
   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0: begin
            return 32'h0;
         end
         1: begin
            return 32'hFFFF_FFFF;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Random post/get traffic. Every 40 beats the mix shifts between filling,
   // balanced and draining, with a favored priority, so the queues swing
   // between empty and full. Midway, and now and then at random, hold the
   // sender until the mailbox has answered everything.
   task automatic random_traffic(int unsigned count);
      int unsigned i;
      int unsigned post_pct;
      int unsigned roll;
      logic [1:0]  fav_prio;
      logic [1:0]  op;
      logic [1:0]  prio;
      post_pct = 50;
      fav_prio = PRIO_HIGH;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: post_pct = 85;
               1: post_pct = 50;
               default: post_pct = 20;
            endcase
            fav_prio = 2'($urandom_range(3));
         end
         roll = $urandom_range(99);
         if (roll < 3)
            op = OP_UNKNOWN;
         else if (roll < 3 + post_pct * 97 / 100)
            op = ($urandom_range(99) < 25) ? tlpm_pkg::OP_DIRECT : tlpm_pkg::OP_ROUTED;
         else
            op = tlpm_pkg::OP_GET;
         prio = $urandom_range(1) ? fav_prio : 2'($urandom_range(3));
         if (i == count / 2 || $urandom_range(199) == 0)
            drain_replies();
         send_beat(op, prio, random_word(), random_word(), 1'b0, NO_REPLY);
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned p;
      int unsigned n;
      int unsigned k;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Write both registers to their reset values before the table
      csr_write(tlpm_pkg::REG_NO_PANIC, 1'b0);
      csr_write(tlpm_pkg::REG_DIRECT_TARGET, 1'b0);

      // Walk the directed table with no idling
      for (int r = 0; r < DRILL_ROWS; r++)
         send_beat(DRILL[r].op, DRILL[r].prio, DRILL[r].payload, DRILL[r].stamp,
                   DRILL[r].typed, DRILL[r].want);
      drain_replies();

      // Random phases; registers change only once the mailbox is quiet
      for (p = 0; p < 4; p++) begin
         csr_write(tlpm_pkg::REG_NO_PANIC, PHASE_NO_PANIC[p]);
         csr_write(tlpm_pkg::REG_DIRECT_TARGET, PHASE_DIRECT[p]);
         send_idle_pct = PHASE_SEND[p];
         recv_stall_pct = PHASE_RECV[p];
         random_traffic(RANDOM_BEATS);
         drain_replies();
      end

      // Overflow run: fill normal through direct posts, then fill high
      // through routed posts and push a few more into it with panics off.
      // Idle off to keep the run short.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      csr_write(tlpm_pkg::REG_NO_PANIC, 1'b1);
      csr_write(tlpm_pkg::REG_DIRECT_TARGET, 1'b0);
      for (k = 0; k < tlpm_pkg::NORMAL_DEPTH + 6; k++)
         send_beat(tlpm_pkg::OP_DIRECT, tlpm_pkg::PRIO_NORMAL, random_word(),
                   random_word(), 1'b0, NO_REPLY);
      n = tlpm_pkg::HIGH_DEPTH + 4;
      for (k = 0; k < n; k++)
         send_beat(tlpm_pkg::OP_ROUTED, (k[0] ? PRIO_OTHER : PRIO_HIGH), $urandom,
                   $urandom, 1'b0, NO_REPLY);
      drain_replies();

      // Switch panic back on so an overflow is seen with fatal high
      csr_write(tlpm_pkg::REG_NO_PANIC, 1'b0);
      send_beat(tlpm_pkg::OP_ROUTED, PRIO_HIGH, 32'h0, 32'h0, 1'b0, NO_REPLY);

      // Empty the mailbox and ask twice more on an empty mailbox
      drain_replies();
      n = box_fill[tlpm_pkg::Q_HIGH] + box_fill[tlpm_pkg::Q_NORMAL] +
          box_fill[tlpm_pkg::Q_LOW] + 2;
      for (k = 0; k < n; k++)
         send_beat(tlpm_pkg::OP_GET, PRIO_HIGH, 32'h0, 32'h0, 1'b0, NO_REPLY);
      drain_replies();

      if (pending_replies.size() != 0)
         report_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
